>>> sv/cevq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cevq_pkg;

    // event kinds
    localparam logic [2:0] EV_KEY_PRESS   = 3'd0;
    localparam logic [2:0] EV_KEY_RELEASE = 3'd1;
    localparam logic [2:0] EV_MOUSE_CLICK = 3'd2;
    localparam logic [2:0] EV_KBD_CLICK   = 3'd3;
    localparam logic [2:0] EV_KBD_MOVE    = 3'd4;
    localparam logic [2:0] EV_RECENTER    = 3'd5;

    // key codes
    localparam logic [2:0] KEY_RETURN = 3'd0;
    localparam logic [2:0] KEY_ESCAPE = 3'd1;
    localparam logic [2:0] KEY_F2     = 3'd2;
    localparam logic [2:0] KEY_UP     = 3'd3;
    localparam logic [2:0] KEY_DOWN   = 3'd4;
    localparam logic [2:0] KEY_LEFT   = 3'd5;
    localparam logic [2:0] KEY_RIGHT  = 3'd6;

    // keyboard move directions
    localparam logic [1:0] MV_UP    = 2'd0;
    localparam logic [1:0] MV_DOWN  = 2'd1;
    localparam logic [1:0] MV_LEFT  = 2'd2;
    localparam logic [1:0] MV_RIGHT = 2'd3;

    // held stick direction
    localparam logic [2:0] DIR_NONE  = 3'd0;
    localparam logic [2:0] DIR_UP    = 3'd1;
    localparam logic [2:0] DIR_DOWN  = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_RIGHT = 3'd4;

    // register indexes
    localparam logic [2:0] CFG_PRESS_LEVEL = 3'd0;
    localparam logic [2:0] CFG_HOLD_LEVEL  = 3'd1;
    localparam logic [2:0] CFG_REPEAT_MS   = 3'd2;
    localparam logic [2:0] CFG_LONG_MS     = 3'd3;
    localparam logic [2:0] CFG_TRIG_LEVEL  = 3'd4;

    localparam int MAX_EVENTS = 8;

    typedef struct packed {
        logic        we;
        logic [2:0]  index;
        logic [15:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic               kbd;
        logic               in_menu;
        logic               menu_btn;
        logic               b_btn;
        logic               a_btn;
        logic               y_btn;
        logic [14:0]        trig;
        logic signed [15:0] stick_y;
        logic signed [15:0] stick_x;
        logic [31:0]        now_ms;
    } t_item;

    typedef struct packed {
        logic [1:0] mv;
        logic [2:0] key;
        logic [2:0] kind;
    } t_event;

    typedef struct packed {
        logic [3:0]                  cnt;
        t_event [MAX_EVENTS-1:0]     ev;
    } t_frame;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    function automatic t_event mk_event(logic [2:0] kind, logic [2:0] key, logic [1:0] mv);
        t_event e;
        e.kind = kind;
        e.key  = key;
        e.mv   = mv;
        return e;
    endfunction

    function automatic logic [2:0] dir_to_key(logic [2:0] d);
        logic [2:0] k;
        unique case (d)
            DIR_UP:    k = KEY_UP;
            DIR_DOWN:  k = KEY_DOWN;
            DIR_LEFT:  k = KEY_LEFT;
            DIR_RIGHT: k = KEY_RIGHT;
            default:   k = KEY_RETURN;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] dir_to_move(logic [2:0] d);
        logic [1:0] m;
        unique case (d)
            DIR_UP:    m = MV_UP;
            DIR_DOWN:  m = MV_DOWN;
            DIR_LEFT:  m = MV_LEFT;
            DIR_RIGHT: m = MV_RIGHT;
            default:   m = MV_UP;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> sv/controller_event_qualifier.sv
`timescale 1ns / 1ps
`default_nettype none

// path: a frame beat writes the frame queue, then the output register loads the first event
//   of that frame; a stalled output register can hold that load back
// throughput: one frame beat per cycle while the frame queue has room; events leave
//   one per cycle while the sink is ready, and a frame causes at most eight events
// frames that cause no event are absorbed in the accepting cycle
// reset: synchronous active low i_rst_n clears edge state, queue and output; registers
//   return to their default levels and intervals
module controller_event_qualifier #(
    parameter int FIFO_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata,
    // frame stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // now_ms[31:0], left_stick_x[47:32], left_stick_y[63:48], right_trigger[78:64],
    // y_button[79], a_button[80], b_button[81], menu_button[82], in_menu[83],
    // keyboard_active[84], zero pad[87:85]
    input  wire logic [87:0] i_s_axis_tdata,
    // event stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // key[2:0], move_dir[4:3], zero pad[7:5]
    output logic [7:0]       o_m_axis_tdata,
    // event_kind[2:0]
    output logic [2:0]       o_m_axis_tuser,
    output logic             o_m_axis_tlast
);
    import cevq_pkg::*;

    t_cfg_wr  cfg;
    t_item    item;
    t_frame   push_frame, head;
    t_q_stat  q_stat;
    t_event   out_ev;
    logic     push, pop;

    // unpack ports
    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_wdata;
    assign item      = i_s_axis_tdata[84:0];

    cevq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_item   (item),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_frame  (push_frame)
    );

    cevq_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    cevq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_event  (out_ev),
        .o_last   (o_m_axis_tlast)
    );

    // pack event beat
    assign o_m_axis_tdata = {3'b000, out_ev.mv, out_ev.key};
    assign o_m_axis_tuser = out_ev.kind;

endmodule

`default_nettype wire

>>> sv/cevq_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cevq_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire cevq_pkg::t_cfg_wr i_cfg,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire cevq_pkg::t_item  i_item,
    input  wire cevq_pkg::t_q_stat i_q_stat,
    output logic                  o_push,
    output cevq_pkg::t_frame      o_frame
);
    import cevq_pkg::*;

    logic [14:0] r_press_level;
    logic [14:0] r_hold_level;
    logic [15:0] r_repeat_ms;
    logic [15:0] r_long_ms;
    logic [14:0] r_trig_level;

    logic        r_prev_y, r_prev_a, r_prev_b, r_prev_menu, r_prev_trig;
    logic [2:0]  r_stick_dir;
    logic [31:0] r_last_stick;
    logic [31:0] r_y_down;
    logic        r_y_recent;

    logic        n_prev_trig;
    logic [2:0]  n_stick_dir;
    logic [31:0] n_last_stick;
    logic [31:0] n_y_down;
    logic        n_y_recent;

    logic        accept;
    t_event [MAX_EVENTS-1:0] ev;
    logic [3:0]  n;

    logic               trig_on;
    logic               y_rise;
    logic signed [16:0] ax, ay, press, hold, held;
    logic [2:0]         dir;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_level <= 15'd12288;
            r_hold_level  <= 15'd5734;
            r_repeat_ms   <= 16'd250;
            r_long_ms     <= 16'd1000;
            r_trig_level  <= 15'd8192;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                CFG_PRESS_LEVEL: r_press_level <= i_cfg.data[14:0];
                CFG_HOLD_LEVEL:  r_hold_level  <= i_cfg.data[14:0];
                CFG_REPEAT_MS:   r_repeat_ms   <= i_cfg.data;
                CFG_LONG_MS:     r_long_ms     <= i_cfg.data;
                CFG_TRIG_LEVEL:  r_trig_level  <= i_cfg.data[14:0];
                default: ;
            endcase
        end
    end

    // classify one frame into an ordered event list
    always_comb begin
        ev           = '0;
        n            = 4'd0;
        n_prev_trig  = r_prev_trig;
        n_stick_dir  = r_stick_dir;
        n_last_stick = r_last_stick;
        n_y_down     = r_y_down;
        n_y_recent   = r_y_recent;
        ax           = {i_item.stick_x[15], i_item.stick_x};
        ay           = {i_item.stick_y[15], i_item.stick_y};
        press        = {2'b00, r_press_level};
        hold         = {2'b00, r_hold_level};
        trig_on      = i_item.trig > r_trig_level;
        y_rise       = i_item.y_btn && !r_prev_y;
        held         = '0;
        dir          = r_stick_dir;

        // trigger click
        if (i_item.in_menu) begin
            if (trig_on && !r_prev_trig) begin
                ev[n[2:0]] = mk_event(i_item.kbd ? EV_KBD_CLICK : EV_MOUSE_CLICK,
                                      KEY_RETURN, MV_UP);
                n = n + 4'd1;
            end
            n_prev_trig = trig_on;
        end

        // y long press and short press
        if (y_rise) begin
            n_y_down   = i_item.now_ms;
            n_y_recent = 1'b0;
        end
        if (i_item.y_btn && !n_y_recent && (i_item.now_ms - n_y_down) > {16'd0, r_long_ms})
        begin
            ev[n[2:0]] = mk_event(EV_RECENTER, KEY_RETURN, MV_UP);
            n = n + 4'd1;
            n_y_recent = 1'b1;
        end
        if (!i_item.y_btn && r_prev_y && !r_y_recent) begin
            ev[n[2:0]] = mk_event(EV_KEY_PRESS, KEY_F2, MV_UP);
            n = n + 4'd1;
            ev[n[2:0]] = mk_event(EV_KEY_RELEASE, KEY_F2, MV_UP);
            n = n + 4'd1;
        end

        // button edges
        if (i_item.a_btn && !r_prev_a) begin
            ev[n[2:0]] = mk_event(EV_KEY_PRESS, KEY_RETURN, MV_UP);
            n = n + 4'd1;
        end
        if (!i_item.a_btn && r_prev_a) begin
            ev[n[2:0]] = mk_event(EV_KEY_RELEASE, KEY_RETURN, MV_UP);
            n = n + 4'd1;
        end
        if (i_item.b_btn && !r_prev_b) begin
            ev[n[2:0]] = mk_event(EV_KEY_PRESS, KEY_ESCAPE, MV_UP);
            n = n + 4'd1;
        end
        if (!i_item.b_btn && r_prev_b) begin
            ev[n[2:0]] = mk_event(EV_KEY_RELEASE, KEY_ESCAPE, MV_UP);
            n = n + 4'd1;
        end
        if (i_item.menu_btn && !r_prev_menu) begin
            ev[n[2:0]] = mk_event(EV_KEY_PRESS, KEY_ESCAPE, MV_UP);
            n = n + 4'd1;
        end
        if (!i_item.menu_btn && r_prev_menu) begin
            ev[n[2:0]] = mk_event(EV_KEY_RELEASE, KEY_ESCAPE, MV_UP);
            n = n + 4'd1;
        end

        // stick qualification with hysteresis and repeat interval
        if (i_item.in_menu) begin
            unique case (r_stick_dir)
                DIR_UP:    held = ay;
                DIR_DOWN:  held = -ay;
                DIR_LEFT:  held = -ax;
                DIR_RIGHT: held = ax;
                default:   held = '0;
            endcase
            if (r_stick_dir != DIR_NONE && held < hold) begin
                dir = DIR_NONE;
            end
            if (dir == DIR_NONE && (i_item.now_ms - r_last_stick) > {16'd0, r_repeat_ms})
            begin
                if (ay > press)       dir = DIR_UP;
                else if (ay < -press) dir = DIR_DOWN;
                else if (ax > press)  dir = DIR_RIGHT;
                else if (ax < -press) dir = DIR_LEFT;
                if (dir != DIR_NONE) n_last_stick = i_item.now_ms;
            end
            if (dir != r_stick_dir) begin
                if (i_item.kbd) begin
                    if (dir != DIR_NONE) begin
                        ev[n[2:0]] = mk_event(EV_KBD_MOVE, KEY_RETURN, dir_to_move(dir));
                        n = n + 4'd1;
                    end
                end else begin
                    if (r_stick_dir != DIR_NONE) begin
                        ev[n[2:0]] = mk_event(EV_KEY_RELEASE, dir_to_key(r_stick_dir), MV_UP);
                        n = n + 4'd1;
                    end
                    if (dir != DIR_NONE) begin
                        ev[n[2:0]] = mk_event(EV_KEY_PRESS, dir_to_key(dir), MV_UP);
                        n = n + 4'd1;
                    end
                end
                n_stick_dir = dir;
            end
        end
    end

    assign o_frame.ev  = ev;
    assign o_frame.cnt = n;
    assign o_push      = accept && (n != 4'd0);

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_y     <= 1'b0;
            r_prev_a     <= 1'b0;
            r_prev_b     <= 1'b0;
            r_prev_menu  <= 1'b0;
            r_prev_trig  <= 1'b0;
            r_stick_dir  <= DIR_NONE;
            r_last_stick <= '0;
            r_y_down     <= '0;
            r_y_recent   <= 1'b0;
        end else if (accept) begin
            r_prev_y     <= i_item.y_btn;
            r_prev_a     <= i_item.a_btn;
            r_prev_b     <= i_item.b_btn;
            r_prev_menu  <= i_item.menu_btn;
            r_prev_trig  <= n_prev_trig;
            r_stick_dir  <= n_stick_dir;
            r_last_stick <= n_last_stick;
            r_y_down     <= n_y_down;
            r_y_recent   <= n_y_recent;
        end
    end

endmodule

`default_nettype wire

>>> sv/cevq_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module cevq_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire cevq_pkg::t_frame  i_frame,
    input  wire logic              i_pop,
    output cevq_pkg::t_frame       o_head,
    output cevq_pkg::t_q_stat      o_stat
);
    import cevq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_frame        r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            if (i_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + CW'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CW'(DEPTH));

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("frame queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("frame queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("frame queue count out of range");
`endif

endmodule

`default_nettype wire

>>> sv/cevq_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cevq_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cevq_pkg::t_frame  i_head,
    input  wire cevq_pkg::t_q_stat i_q_stat,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output cevq_pkg::t_event       o_event,
    output logic                   o_last
);
    import cevq_pkg::*;

    logic [2:0] r_idx;
    logic       r_vld;
    t_event     r_ev;
    logic       r_last;

    logic       load;
    logic       is_last;

    assign load    = !i_q_stat.empty && (!r_vld || i_ready);
    assign is_last = ({1'b0, r_idx} + 4'd1) == i_head.cnt;
    assign o_pop   = load && is_last;

    // walk the events of the head frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (load) begin
            r_idx <= is_last ? 3'd0 : r_idx + 3'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ev   <= i_head.ev[r_idx];
            r_last <= is_last;
        end
    end

    assign o_valid = r_vld;
    assign o_event = r_ev;
    assign o_last  = r_last;

`ifndef ASSERT_OFF
    a_head_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_stat.empty |-> (i_head.cnt != 4'd0))
        else $error("queued frame holds no events");
    a_idx_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_stat.empty |-> ({1'b0, r_idx} < i_head.cnt))
        else $error("event index past end of frame");
    a_idx_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_stat.empty |-> (r_idx == 3'd0))
        else $error("event index not cleared between frames");
`endif

endmodule

`default_nettype wire

>>> tb/sv/controller_event_qualifier_tb.sv
`timescale 1ns / 1ps

module controller_event_qualifier_tb;

    import cevq_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS = 10;

    // one expected event as it should leave the block
    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] key;
        logic [1:0] mv;
        logic       last;
    } ev_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = CFG_PRESS_LEVEL;
    logic [15:0] i_cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic [87:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [7:0]  o_m_axis_tdata;
    wire  [2:0]  o_m_axis_tuser;
    wire         o_m_axis_tlast;

    controller_event_qualifier i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // frames waiting to be sent and events waiting to arrive
    t_item frame_q[$];
    ev_t   event_q[$];

    // predictor copy of the registers
    logic [14:0] press_lvl;
    logic [14:0] hold_lvl;
    logic [15:0] repeat_ms;
    logic [15:0] long_ms;
    logic [14:0] trig_lvl;

    // predictor copy of the edge and stick state
    logic        was_y, was_a, was_b, was_menu, was_trig_on;
    logic [2:0]  held_dir;
    logic [31:0] dir_time;
    logic [31:0] y_press_time;
    logic        y_long_done;

    // events of the frame being qualified
    ev_t frame_ev[MAX_EVENTS];
    int  frame_n;

    logic s_beat = 1'b0;
    logic calm = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   quiet = 0;
    int   mismatches = 0;
    int   frames_sent = 0;
    int   events_seen = 0;
    int   settings_used = 0;

    // random sequence state
    logic [31:0] gen_now;
    logic        gen_y, gen_a, gen_b, gen_m, gen_menu, gen_kbd;
    int          gen_sx, gen_sy;

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    task automatic add_event(input logic [2:0] kind, input logic [2:0] key,
                             input logic [1:0] mv);
        frame_ev[frame_n] = '{kind: kind, key: key, mv: mv, last: 1'b0};
        frame_n++;
    endtask

    task automatic clear_state;
        press_lvl = 15'd12288;
        hold_lvl = 15'd5734;
        repeat_ms = 16'd250;
        long_ms = 16'd1000;
        trig_lvl = 15'd8192;
        {was_y, was_a, was_b, was_menu, was_trig_on} = '0;
        held_dir = DIR_NONE;
        dir_time = '0;
        y_press_time = '0;
        y_long_done = 1'b0;
    endtask

    // compute the events of one frame and queue them
    task automatic qualify_frame(input t_item f);
        int          sx, sy, held;
        logic        on;
        logic [2:0]  dir;
        logic [31:0] dt;
        begin
            frame_n = 0;
            sx = $signed(f.stick_x);
            sy = $signed(f.stick_y);
            // trigger edge, only in menus
            if (f.in_menu) begin
                on = f.trig > trig_lvl;
                if (on && !was_trig_on)
                    add_event(f.kbd ? EV_KBD_CLICK : EV_MOUSE_CLICK, KEY_RETURN, MV_UP);
                was_trig_on = on;
            end
            // y button: short press is F2, long hold is a recenter
            if (f.y_btn && !was_y) begin
                y_press_time = f.now_ms;
                y_long_done = 1'b0;
            end
            dt = f.now_ms - y_press_time;
            if (f.y_btn && !y_long_done && dt > long_ms) begin
                add_event(EV_RECENTER, KEY_RETURN, MV_UP);
                y_long_done = 1'b1;
            end
            if (!f.y_btn && was_y && !y_long_done) begin
                add_event(EV_KEY_PRESS, KEY_F2, MV_UP);
                add_event(EV_KEY_RELEASE, KEY_F2, MV_UP);
            end
            // plain button edges
            if (f.a_btn && !was_a) add_event(EV_KEY_PRESS, KEY_RETURN, MV_UP);
            if (!f.a_btn && was_a) add_event(EV_KEY_RELEASE, KEY_RETURN, MV_UP);
            if (f.b_btn && !was_b) add_event(EV_KEY_PRESS, KEY_ESCAPE, MV_UP);
            if (!f.b_btn && was_b) add_event(EV_KEY_RELEASE, KEY_ESCAPE, MV_UP);
            if (f.menu_btn && !was_menu) add_event(EV_KEY_PRESS, KEY_ESCAPE, MV_UP);
            if (!f.menu_btn && was_menu) add_event(EV_KEY_RELEASE, KEY_ESCAPE, MV_UP);
            // stick direction with hysteresis and repeat interval
            if (f.in_menu) begin
                dir = held_dir;
                if (dir != DIR_NONE) begin
                    case (dir)
                        DIR_UP:    held = sy;
                        DIR_DOWN:  held = -sy;
                        DIR_RIGHT: held = sx;
                        default:   held = -sx;
                    endcase
                    if (held < int'(hold_lvl)) dir = DIR_NONE;
                end
                dt = f.now_ms - dir_time;
                if (dir == DIR_NONE && dt > repeat_ms) begin
                    if (sy > int'(press_lvl)) dir = DIR_UP;
                    else if (sy < -int'(press_lvl)) dir = DIR_DOWN;
                    else if (sx > int'(press_lvl)) dir = DIR_RIGHT;
                    else if (sx < -int'(press_lvl)) dir = DIR_LEFT;
                    if (dir != DIR_NONE) dir_time = f.now_ms;
                end
                if (dir != held_dir) begin
                    if (f.kbd) begin
                        if (dir != DIR_NONE)
                            add_event(EV_KBD_MOVE, KEY_RETURN, 2'(dir - DIR_UP));
                    end else begin
                        if (held_dir != DIR_NONE)
                            add_event(EV_KEY_RELEASE, 3'(held_dir + (KEY_UP - DIR_UP)), MV_UP);
                        if (dir != DIR_NONE)
                            add_event(EV_KEY_PRESS, 3'(dir + (KEY_UP - DIR_UP)), MV_UP);
                    end
                    held_dir = dir;
                end
            end
            was_y = f.y_btn;
            was_a = f.a_btn;
            was_b = f.b_btn;
            was_menu = f.menu_btn;
            if (frame_n > 0) frame_ev[frame_n - 1].last = 1'b1;
            for (int i = 0; i < frame_n; i++) event_q.push_back(frame_ev[i]);
        end
    endtask

    // sample both streams, check events, predict on frame beats
    always @(posedge i_clk) begin : monitor
        ev_t want;
        logic m_beat;
        if (i_rst_n) begin
            m_beat = o_m_axis_tvalid && m_tready;
            if (m_beat) begin
                events_seen++;
                if (event_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected event kind=%0d tdata=%h last=%0b",
                        o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast));
                end else begin
                    want = event_q.pop_front();
                    if (o_m_axis_tuser !== want.kind
                            || o_m_axis_tdata !== {3'b000, want.mv, want.key}
                            || o_m_axis_tlast !== want.last)
                        flag_mismatch($sformatf(
                            "exp kind=%0d key=%0d mv=%0d last=%0b, got kind=%0d tdata=%h last=%0b",
                            want.kind, want.key, want.mv, want.last,
                            o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast));
                end
            end
            s_beat = s_tvalid && o_s_axis_tready;
            if (s_beat) begin
                frames_sent++;
                qualify_frame(t_item'(s_tdata[84:0]));
            end
            // watchdog on cycles without any beat
            if (s_beat || m_beat) quiet = 0;
            else quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("timeout after %0d quiet cycles", quiet);
                $display("tb: failure");
                $finish;
            end
        end else begin
            s_beat = 1'b0;
        end
    end

    // frame driver with random gaps
    always @(negedge i_clk) begin : frame_driver
        t_item f;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_beat) begin
            // hold the beat until taken
        end else if (gap_left != 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (!calm && frame_q.size() != 0 && $urandom_range(0, 99) < 15) begin
            gap_left = $urandom_range(0, 13);
            s_tvalid <= 1'b0;
        end else if (frame_q.size() != 0) begin
            f = frame_q.pop_front();
            s_tdata <= {3'b000, f};
            s_tvalid <= 1'b1;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // event sink with random stalls
    always @(negedge i_clk) begin : event_sink
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 12) begin
            stall_left = $urandom_range(0, 13);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic t_item mk_frame(input logic [31:0] now, input int sx, input int sy,
                                       input int trig, input logic [5:0] flags);
        t_item f;
        f.now_ms = now;
        f.stick_x = 16'(sx);
        f.stick_y = 16'(sy);
        f.trig = 15'(trig);
        // flags from low bit: y, a, b, menu button, in menu, keyboard shown
        {f.kbd, f.in_menu, f.menu_btn, f.b_btn, f.a_btn, f.y_btn} = flags;
        return f;
    endfunction

    // register write, mirrored into the predictor
    task automatic cfg_write(input logic [2:0] index, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        case (index)
            CFG_PRESS_LEVEL: press_lvl = value[14:0];
            CFG_HOLD_LEVEL:  hold_lvl = value[14:0];
            CFG_REPEAT_MS:   repeat_ms = value;
            CFG_LONG_MS:     long_ms = value;
            CFG_TRIG_LEVEL:  trig_lvl = value[14:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic cfg_all(input logic [15:0] press, input logic [15:0] hold,
                           input logic [15:0] rep, input logic [15:0] lng,
                           input logic [15:0] trig);
        cfg_write(CFG_PRESS_LEVEL, press);
        cfg_write(CFG_HOLD_LEVEL, hold);
        cfg_write(CFG_REPEAT_MS, rep);
        cfg_write(CFG_LONG_MS, lng);
        cfg_write(CFG_TRIG_LEVEL, trig);
        settings_used++;
    endtask

    // wait until the block has nothing left to do
    task automatic drain;
        while (frame_q.size() != 0 || s_tvalid || event_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random frames: mostly plausible controller motion, some raw noise
    task automatic random_frames(input int count);
        int r, mag;
        t_item f;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60) gen_now += $urandom_range(20, 400);
            else if (r < 85) gen_now += $urandom_range(0, 60);
            else if (r < 95) gen_now += $urandom_range(300, 2500);
            else gen_now = $urandom;
            if ($urandom_range(0, 99) < 15) gen_y = ~gen_y;
            if ($urandom_range(0, 99) < 20) gen_a = ~gen_a;
            if ($urandom_range(0, 99) < 20) gen_b = ~gen_b;
            if ($urandom_range(0, 99) < 15) gen_m = ~gen_m;
            gen_menu = $urandom_range(0, 99) < 85;
            if ($urandom_range(0, 99) < 10) gen_kbd = ~gen_kbd;
            r = $urandom_range(0, 99);
            if (r < 30) begin
                gen_sx = int'($urandom_range(0, 8000)) - 4000;
                gen_sy = int'($urandom_range(0, 8000)) - 4000;
            end else if (r < 70) begin
                mag = int'($urandom_range(10000, 16384));
                gen_sx = int'($urandom_range(0, 6000)) - 3000;
                gen_sy = int'($urandom_range(0, 6000)) - 3000;
                case ($urandom_range(0, 3))
                    0: gen_sy = mag;
                    1: gen_sy = -mag;
                    2: gen_sx = mag;
                    default: gen_sx = -mag;
                endcase
            end else if (r < 85) begin
                gen_sx = int'($urandom_range(0, 16000)) - 8000;
                gen_sy = int'($urandom_range(0, 16000)) - 8000;
            end else if (r >= 95) begin
                gen_sx = $signed(16'($urandom));
                gen_sy = $signed(16'($urandom));
            end
            f = mk_frame(gen_now, gen_sx, gen_sy, 0,
                         {gen_kbd, gen_menu, gen_m, gen_b, gen_a, gen_y});
            r = $urandom_range(0, 99);
            if (r < 50) f.trig = 15'($urandom_range(0, 7000));
            else if (r < 85) f.trig = 15'($urandom_range(9000, 16384));
            else if (r < 95) f.trig = 15'((trig_lvl < 2) ? trig_lvl + $urandom_range(0, 2)
                                    : (trig_lvl > 32765) ? trig_lvl - $urandom_range(0, 2)
                                    : trig_lvl + $urandom_range(0, 4) - 2);
            else f.trig = 15'($urandom);
            frame_q.push_back(f);
        end
    endtask

    // directed frames at the reset register values
    task automatic directed_frames;
        // flag bits from low: y, a, b, menu button, in menu, keyboard shown
        frame_q.push_back(mk_frame(100, 0, 0, 0, 6'b010000));
        frame_q.push_back(mk_frame(300, 0, 16384, 16384, 6'b010000));
        frame_q.push_back(mk_frame(310, 0, 16384, 8192, 6'b011111));
        frame_q.push_back(mk_frame(320, 0, -16384, 8193, 6'b010001));
        frame_q.push_back(mk_frame(330, 0, 0, 0, 6'b010000));
        // long y hold: exactly the limit, then just past it
        frame_q.push_back(mk_frame(400, 0, 0, 0, 6'b010001));
        frame_q.push_back(mk_frame(1400, 0, 0, 0, 6'b010001));
        frame_q.push_back(mk_frame(1401, 0, 0, 0, 6'b010001));
        frame_q.push_back(mk_frame(1500, 0, 0, 0, 6'b010000));
        // keyboard shown: click, move, return to center
        frame_q.push_back(mk_frame(2000, 16384, 0, 16384, 6'b110000));
        frame_q.push_back(mk_frame(2010, 0, 0, 0, 6'b110000));
        // out of menu: trigger and stick ignored
        frame_q.push_back(mk_frame(2100, -16384, 0, 16384, 6'b000000));
        // setup frame, then a full frame of eight events
        frame_q.push_back(mk_frame(2500, 16384, 0, 0, 6'b011111));
        frame_q.push_back(mk_frame(2800, -16384, 0, 16384, 6'b010000));
        // time wrap around zero
        frame_q.push_back(mk_frame(32'hFFFF_FF00, 0, 16384, 0, 6'b010000));
        frame_q.push_back(mk_frame(32'h0000_0010, 0, 0, 0, 6'b010000));
        frame_q.push_back(mk_frame(32'h0000_0020, 0, 12288, 0, 6'b010000));
        frame_q.push_back(mk_frame(32'h0000_0021, 0, 12289, 0, 6'b010000));
        // stick beyond the nominal range, diagonal priority
        frame_q.push_back(mk_frame(32'h0000_0200, -32768, 0, 0, 6'b010000));
        frame_q.push_back(mk_frame(32'h0000_0400, 32767, -16384, 0, 6'b010000));
        frame_q.push_back(mk_frame(32'h8000_0000, 0, 0, 32767, 6'b010001));
        frame_q.push_back(mk_frame(32'h8000_03E9, 0, 16384, 0, 6'b110001));
        frame_q.push_back(mk_frame(32'h8000_0400, 16384, 0, 0, 6'b110000));
    endtask

    initial begin
        clear_state();
        gen_now = 32'd5000;
        {gen_y, gen_a, gen_b, gen_m, gen_menu, gen_kbd} = '0;
        gen_sx = 0;
        gen_sy = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        settings_used = 1;

        directed_frames();
        drain();
        random_frames(45);
        drain();

        // lowest levels and intervals, plus ignored indexes
        cfg_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        cfg_write(3'd5, 16'hFFFF);
        cfg_write(3'd6, 16'h5555);
        cfg_write(3'd7, 16'hAAAA);
        random_frames(40);
        drain();

        // highest values; bit 15 of a level write is dropped
        cfg_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_frames(35);
        drain();

        // random mid-range setting
        cfg_all(16'($urandom_range(8000, 16384)), 16'($urandom_range(0, 8000)),
                16'($urandom_range(0, 600)), 16'($urandom_range(0, 1500)),
                16'($urandom_range(0, 16384)));
        random_frames(40);
        drain();

        // last stretch at reset values with no idling
        cfg_all(16'd12288, 16'd5734, 16'd250, 16'd1000, 16'd8192);
        calm = 1'b1;
        random_frames(35);
        drain();
        repeat (8) @(posedge i_clk);

        if (event_q.size() != 0)
            flag_mismatch($sformatf("%0d expected events never arrived", event_q.size()));
        $display("ran %0d frames over %0d register settings, %0d events checked",
                 frames_sent, settings_used, events_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> controller_event_qualifier.f
sv/cevq_pkg.sv
sv/cevq_front.sv
sv/cevq_fifo.sv
sv/cevq_back.sv
sv/controller_event_qualifier.sv
tb/sv/controller_event_qualifier_tb.sv
